// ----- src/vwc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vwc_pkg: shared types and constants of the vertex weld cluster block
// Item structs, controller/datapath command and status groups, and codes.
// ----------------------------------------------------------------------------
package vwc_pkg;

  localparam int MAX_CLUSTERS = 64;
  localparam int IDX_W        = $clog2(MAX_CLUSTERS);
  localparam int CNT_W        = $clog2(MAX_CLUSTERS + 1);
  localparam int SUM_W        = 40;
  localparam int HIT_W        = 16;
  localparam int POS_W        = 24;
  localparam int RAD_W        = 48;
  localparam int DIV_STEPS    = SUM_W;
  localparam int DCNT_W       = $clog2(DIV_STEPS + 1);

  // Configuration register addresses.
  localparam logic [3:0] ADDR_RADIUS = 4'd0;

  // Request codes.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_MERGED    = 3'd0;
  localparam logic [2:0] ST_NEW       = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  localparam logic [HIT_W-1:0] HIT_MAX = '1;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [5:0]              read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [5:0]              cluster_index;
    logic signed [POS_W-1:0] avg_x;
    logic signed [POS_W-1:0] avg_y;
    logic signed [POS_W-1:0] avg_z;
    logic [6:0]              cluster_count;
  } out_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
    logic [HIT_W-1:0]        hits;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_LOAD, S_DIVGO, S_DIV, S_CMP, S_UPD, S_NEW_WR, S_EMIT
  } state_t;

  // What the result register is loaded with.
  typedef enum logic [1:0] {
    RES_CENT,   // current index and divider quotients
    RES_VERT,   // current index and the vertex itself
    RES_ZERO,   // index zero and zero position
    RES_BADRD   // requested read index and zero position
  } res_sel_t;

  typedef struct packed {
    logic       cap_in;
    logic       idx_clr;
    logic       idx_inc;
    logic       idx_load_read;
    logic       mem_rd;
    logic       mem_wr;
    logic       load_work_rd;
    logic       load_work_add;
    logic       load_work_new;
    logic       div_start;
    logic       sq_en;
    logic       used_inc;
    logic       used_clr;
    logic       res_load;
    res_sel_t   res_sel;
    logic [2:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       div_done;
    logic       match;
    logic       hit_sat;
    logic       scan_end;
    logic       full;
    logic       read_bad;
    logic       out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ----- src/vwc_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vwc_div: three-lane iterative centroid divider
// Divides three signed sums by one hit count, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module vwc_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire vwc_pkg::entry_t               operand,
  output logic                               done,
  output logic signed [vwc_pkg::POS_W-1:0]   q_x,
  output logic signed [vwc_pkg::POS_W-1:0]   q_y,
  output logic signed [vwc_pkg::POS_W-1:0]   q_z
);

  logic [vwc_pkg::SUM_W-1:0]  mag [3];
  logic [vwc_pkg::HIT_W-1:0]  rem [3];
  logic                       neg [3];
  logic [vwc_pkg::HIT_W:0]    rem_sh [3];
  logic                       ge [3];
  logic signed [vwc_pkg::SUM_W-1:0] sums [3];
  logic signed [vwc_pkg::POS_W-1:0] quo [3];
  logic [vwc_pkg::HIT_W-1:0]  hits;
  logic [vwc_pkg::DCNT_W-1:0] cnt;
  logic                       busy;

  assign sums[0] = operand.sum_x;
  assign sums[1] = operand.sum_y;
  assign sums[2] = operand.sum_z;

  // One restoring step per lane.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {rem[i], mag[i][vwc_pkg::SUM_W-1]};
      ge[i]     = rem_sh[i] >= {1'b0, hits};
    end
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == vwc_pkg::DCNT_W'(vwc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Lane registers: magnitude shifts out dividend bits and in quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      hits <= operand.hits;
      for (int i = 0; i < 3; i++) begin
        neg[i] <= sums[i][vwc_pkg::SUM_W-1];
        mag[i] <= sums[i][vwc_pkg::SUM_W-1] ? -sums[i] : sums[i];
        rem[i] <= '0;
      end
    end else if (busy) begin
      for (int i = 0; i < 3; i++) begin
        rem[i] <= ge[i] ? vwc_pkg::HIT_W'(rem_sh[i] - {1'b0, hits})
                        : rem_sh[i][vwc_pkg::HIT_W-1:0];
        mag[i] <= {mag[i][vwc_pkg::SUM_W-2:0], ge[i]};
      end
    end
  end

  // Signed quotient; a zero hit count yields zero.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (hits == '0) begin
        quo[i] = '0;
      end else if (neg[i]) begin
        quo[i] = -mag[i][vwc_pkg::POS_W-1:0];
      end else begin
        quo[i] = mag[i][vwc_pkg::POS_W-1:0];
      end
    end
  end

  assign q_x = quo[0];
  assign q_y = quo[1];
  assign q_z = quo[2];

endmodule
`default_nettype wire

// ----- src/vwc_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vwc_datapath: cluster table, divider, distance check and result register
// Executes the commands of the controller and reports status back.
// ----------------------------------------------------------------------------
module vwc_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire vwc_pkg::cmd_t               cmd,
  output vwc_pkg::stat_t                   stat,
  input  wire vwc_pkg::in_item_t           in_data,
  input  wire logic [vwc_pkg::RAD_W-1:0]   radius_squared,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output vwc_pkg::out_item_t               out_data
);

  vwc_pkg::in_item_t           item;
  vwc_pkg::entry_t             mem [vwc_pkg::MAX_CLUSTERS];
  vwc_pkg::entry_t             rd_q;
  vwc_pkg::entry_t             work;
  logic [vwc_pkg::CNT_W-1:0]   idx;
  logic [vwc_pkg::CNT_W-1:0]   used;
  logic                        div_done;
  logic signed [vwc_pkg::POS_W-1:0] q_x, q_y, q_z;
  logic signed [vwc_pkg::POS_W:0]   dx, dy, dz;
  logic signed [2*vwc_pkg::POS_W+1:0] px, py, pz;
  logic [2*vwc_pkg::POS_W:0]   sq_x, sq_y, sq_z;
  logic [2*vwc_pkg::POS_W+1:0] dist_sq;

  // Captured request.
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      item <= in_data;
    end
  end

  // Scan index and table fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      used <= '0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end else if (cmd.idx_load_read) begin
        idx <= vwc_pkg::CNT_W'(item.read_index);
      end
      if (cmd.used_clr) begin
        used <= '0;
      end else if (cmd.used_inc) begin
        used <= used + 1'b1;
      end
    end
  end

  // Cluster table memory, registered read.
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[idx[vwc_pkg::IDX_W-1:0]] <= work;
    end
    if (cmd.mem_rd) begin
      rd_q <= mem[idx[vwc_pkg::IDX_W-1:0]];
    end
  end

  // Working entry: loaded from memory, updated by a merge, or opened new.
  always_ff @(posedge clk) begin
    if (cmd.load_work_rd) begin
      work <= rd_q;
    end else if (cmd.load_work_add) begin
      work.sum_x <= work.sum_x + vwc_pkg::SUM_W'(item.pos_x);
      work.sum_y <= work.sum_y + vwc_pkg::SUM_W'(item.pos_y);
      work.sum_z <= work.sum_z + vwc_pkg::SUM_W'(item.pos_z);
      work.hits  <= work.hits + 1'b1;
    end else if (cmd.load_work_new) begin
      work.sum_x <= vwc_pkg::SUM_W'(item.pos_x);
      work.sum_y <= vwc_pkg::SUM_W'(item.pos_y);
      work.sum_z <= vwc_pkg::SUM_W'(item.pos_z);
      work.hits  <= vwc_pkg::HIT_W'(1);
    end
  end

  vwc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .operand (work),
    .done    (div_done),
    .q_x     (q_x),
    .q_y     (q_y),
    .q_z     (q_z)
  );

  // Squared distance: square each difference, then sum and compare.
  always_comb begin
    dx = (vwc_pkg::POS_W+1)'(item.pos_x) - (vwc_pkg::POS_W+1)'(q_x);
    dy = (vwc_pkg::POS_W+1)'(item.pos_y) - (vwc_pkg::POS_W+1)'(q_y);
    dz = (vwc_pkg::POS_W+1)'(item.pos_z) - (vwc_pkg::POS_W+1)'(q_z);
    px = dx * dx;
    py = dy * dy;
    pz = dz * dz;
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      sq_x <= px[2*vwc_pkg::POS_W:0];
      sq_y <= py[2*vwc_pkg::POS_W:0];
      sq_z <= pz[2*vwc_pkg::POS_W:0];
    end
  end

  assign dist_sq = (2*vwc_pkg::POS_W+2)'(sq_x) + (2*vwc_pkg::POS_W+2)'(sq_y)
                 + (2*vwc_pkg::POS_W+2)'(sq_z);

  // Result register; the controller loads it only when it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data.status        <= cmd.res_status;
      out_data.cluster_count <= 7'(used);
      unique case (cmd.res_sel)
        vwc_pkg::RES_CENT: begin
          out_data.cluster_index <= 6'(idx);
          out_data.avg_x <= q_x;
          out_data.avg_y <= q_y;
          out_data.avg_z <= q_z;
        end
        vwc_pkg::RES_VERT: begin
          out_data.cluster_index <= 6'(idx);
          out_data.avg_x <= item.pos_x;
          out_data.avg_y <= item.pos_y;
          out_data.avg_z <= item.pos_z;
        end
        vwc_pkg::RES_ZERO: begin
          out_data.cluster_index <= '0;
          out_data.avg_x <= '0;
          out_data.avg_y <= '0;
          out_data.avg_z <= '0;
        end
        default: begin
          out_data.cluster_index <= item.read_index;
          out_data.avg_x <= '0;
          out_data.avg_y <= '0;
          out_data.avg_z <= '0;
        end
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.req_type = item.req_type;
    stat.div_done = div_done;
    stat.match    = dist_sq <= (2*vwc_pkg::POS_W+2)'(radius_squared);
    stat.hit_sat  = work.hits == vwc_pkg::HIT_MAX;
    stat.scan_end = idx == used;
    stat.full     = used == vwc_pkg::CNT_W'(vwc_pkg::MAX_CLUSTERS);
    stat.read_bad = vwc_pkg::CNT_W'(item.read_index) >= used;
    stat.out_busy = out_valid;
  end

endmodule
`default_nettype wire

// ----- src/vwc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vwc_ctrl: sequencer of the vertex weld cluster block
// Walks the cluster table for inserts, runs reads and clears, and loads
// the result register.
// ----------------------------------------------------------------------------
module vwc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire vwc_pkg::stat_t  stat,
  output vwc_pkg::cmd_t        cmd
);

  vwc_pkg::state_t   state, state_next;
  logic              final_div, final_div_next;
  vwc_pkg::res_sel_t pend_sel, pend_sel_next;
  logic [2:0]        pend_status, pend_status_next;

  // State and pending-result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= vwc_pkg::S_IDLE;
      final_div   <= 1'b0;
      pend_sel    <= vwc_pkg::RES_ZERO;
      pend_status <= vwc_pkg::ST_MERGED;
    end else begin
      state       <= state_next;
      final_div   <= final_div_next;
      pend_sel    <= pend_sel_next;
      pend_status <= pend_status_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next       = state;
    final_div_next   = final_div;
    pend_sel_next    = pend_sel;
    pend_status_next = pend_status;
    cmd              = '0;
    cmd.res_sel      = pend_sel;
    cmd.res_status   = pend_status;
    in_ready         = 1'b0;

    unique case (state)
      vwc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_next = vwc_pkg::S_DISPATCH;
        end
      end
      vwc_pkg::S_DISPATCH: begin
        priority if (stat.req_type == vwc_pkg::REQ_INSERT) begin
          cmd.idx_clr    = 1'b1;
          final_div_next = 1'b0;
          state_next     = vwc_pkg::S_SCAN;
        end else if (stat.req_type == vwc_pkg::REQ_READ) begin
          if (stat.read_bad) begin
            pend_sel_next    = vwc_pkg::RES_BADRD;
            pend_status_next = vwc_pkg::ST_BAD_INDEX;
            state_next       = vwc_pkg::S_EMIT;
          end else begin
            cmd.idx_load_read = 1'b1;
            final_div_next    = 1'b1;
            state_next        = vwc_pkg::S_SCAN;
          end
        end else if (stat.req_type == vwc_pkg::REQ_CLEAR) begin
          cmd.used_clr     = 1'b1;
          pend_sel_next    = vwc_pkg::RES_ZERO;
          pend_status_next = vwc_pkg::ST_MERGED;
          state_next       = vwc_pkg::S_EMIT;
        end else begin
          pend_sel_next    = vwc_pkg::RES_ZERO;
          pend_status_next = vwc_pkg::ST_BAD_INDEX;
          state_next       = vwc_pkg::S_EMIT;
        end
      end
      vwc_pkg::S_SCAN: begin
        // A read goes straight to its entry; an insert stops at the fill count.
        if (stat.scan_end && !final_div) begin
          if (stat.full) begin
            pend_sel_next    = vwc_pkg::RES_ZERO;
            pend_status_next = vwc_pkg::ST_FULL;
            state_next       = vwc_pkg::S_EMIT;
          end else begin
            cmd.load_work_new = 1'b1;
            state_next        = vwc_pkg::S_NEW_WR;
          end
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = vwc_pkg::S_LOAD;
        end
      end
      vwc_pkg::S_LOAD: begin
        cmd.load_work_rd = 1'b1;
        state_next       = vwc_pkg::S_DIVGO;
      end
      vwc_pkg::S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = vwc_pkg::S_DIV;
      end
      vwc_pkg::S_DIV: begin
        if (stat.div_done) begin
          if (final_div) begin
            pend_sel_next    = vwc_pkg::RES_CENT;
            pend_status_next = vwc_pkg::ST_MERGED;
            state_next       = vwc_pkg::S_EMIT;
          end else begin
            cmd.sq_en  = 1'b1;
            state_next = vwc_pkg::S_CMP;
          end
        end
      end
      vwc_pkg::S_CMP: begin
        if (stat.match) begin
          if (stat.hit_sat) begin
            pend_sel_next    = vwc_pkg::RES_CENT;
            pend_status_next = vwc_pkg::ST_SATURATED;
            state_next       = vwc_pkg::S_EMIT;
          end else begin
            cmd.load_work_add = 1'b1;
            state_next        = vwc_pkg::S_UPD;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = vwc_pkg::S_SCAN;
        end
      end
      vwc_pkg::S_UPD: begin
        // Store the merged entry and recompute its centroid.
        cmd.mem_wr     = 1'b1;
        cmd.div_start  = 1'b1;
        final_div_next = 1'b1;
        state_next     = vwc_pkg::S_DIV;
      end
      vwc_pkg::S_NEW_WR: begin
        cmd.mem_wr       = 1'b1;
        cmd.used_inc     = 1'b1;
        pend_sel_next    = vwc_pkg::RES_VERT;
        pend_status_next = vwc_pkg::ST_NEW;
        state_next       = vwc_pkg::S_EMIT;
      end
      vwc_pkg::S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = vwc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = vwc_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/vertex_weld_cluster.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_weld_cluster: leader-clustering vertex welder, Q15.8 fixed point
// Top level: configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready as one beat each (insert, read, clear);
// every request gives exactly one result beat on out_valid/out_ready.
// The weld radius squared is written over the APB port at address 0.
// A request is taken only when the sequencer is idle. An insert walks
// the stored clusters in order; each takes one registered table read,
// a bit-serial divide of the three sums by the hit count, then a
// squared-distance compare. A merge runs the divider once more for the
// new centroid. A read of a stored entry runs one divide; clear, unknown
// requests and bad reads skip the divider.
// The result sits in an output register; a new request is taken while it
// waits, and the next result is held back until the receiver takes it.
// Reset clears the fill count and the radius; table entries are not cleared
// and are only read once written.
// ----------------------------------------------------------------------------
module vertex_weld_cluster (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire vwc_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output vwc_pkg::out_item_t       out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [63:0]         pwdata,
  output logic [63:0]              prdata,
  output logic                     pready
);

  logic [vwc_pkg::RAD_W-1:0] radius_squared;
  vwc_pkg::cmd_t             cmd;
  vwc_pkg::stat_t            stat;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_squared <= '0;
    end else if (psel && penable && pwrite && paddr == vwc_pkg::ADDR_RADIUS) begin
      radius_squared <= pwdata[vwc_pkg::RAD_W-1:0];
    end
  end
  assign prdata = (paddr == vwc_pkg::ADDR_RADIUS) ? 64'(radius_squared) : '0;

  vwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vwc_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_data        (in_data),
    .radius_squared (radius_squared),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

  // A request keeps the sequencer busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the sequencer was busy");

  // The result register is never overwritten while a beat is pending.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !out_valid)
    else $error("result loaded over a pending beat");

  // The fill count never exceeds the table depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.used_inc |-> !stat.full)
    else $error("cluster opened in a full table");

  // A reported count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.cluster_count <= 7'(vwc_pkg::MAX_CLUSTERS))
    else $error("cluster count out of range");

endmodule
`default_nettype wire

// ----- tb/vertex_weld_cluster_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_weld_cluster_tb: self-checking bench for the vertex weld cluster
// A directed table covers empty-table reads, coordinate extremes, merges,
// clears and unknown requests. A fill pass and then random phases follow,
// each random phase with its own weld radius and handshake idling. These use
// clustered vertices, noise, reads and clears; the fill pass fills the table until it reports full.
// Every result beat is checked field by field against a cluster-table model.
// ----------------------------------------------------------------------------
module vertex_weld_cluster_tb;

  localparam int          CLK_HALF    = 6;
  localparam int          STALL_LIMIT = 40000;
  localparam logic [1:0]  REQ_BAD     = 2'd3;
  localparam logic [47:0] RADIUS_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [vwc_pkg::POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [vwc_pkg::POS_W-1:0] POS_MIN = 24'sh800000;
  localparam logic signed [vwc_pkg::POS_W-1:0] P0      = 24'sd0;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  vwc_pkg::in_item_t   in_data;
  logic                out_valid;
  logic                out_ready;
  vwc_pkg::out_item_t  out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [63:0]         pwdata;
  logic [63:0]         prdata;
  logic                pready;

  vertex_weld_cluster u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Cluster table as the bench sees it.
  longint      acc_x [vwc_pkg::MAX_CLUSTERS];
  longint      acc_y [vwc_pkg::MAX_CLUSTERS];
  longint      acc_z [vwc_pkg::MAX_CLUSTERS];
  longint      hits  [vwc_pkg::MAX_CLUSTERS];
  int          n_used;
  logic [47:0] weld_r2;

  vwc_pkg::out_item_t pending_results[$];
  vwc_pkg::out_item_t mon_pred;
  int          errors;
  int          quiet_cycles;
  int          in_idle_pct;
  int          out_stall_pct;

  // Typed answer of the directed row being sent, driven along with the beat.
  logic               row_fixed;
  vwc_pkg::out_item_t row_want;

  // Directed rows; a row either carries its own answer or defers to the model.
  typedef struct {
    vwc_pkg::in_item_t  req;
    bit                 fixed;
    vwc_pkg::out_item_t want;
  } vec_row_t;
  vec_row_t vecs[$];

  logic signed [vwc_pkg::POS_W-1:0] centers[8][3];

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic longint unsigned sqr(longint v);
    return longint'(v * v);
  endfunction

  // Applies one request to the cluster table and returns the answer beat.
  function automatic vwc_pkg::out_item_t weld_predict(vwc_pkg::in_item_t it);
    vwc_pkg::out_item_t r;
    longint          px, py, pz, cx, cy, cz;
    longint unsigned d;
    int              i;
    px = it.pos_x;
    py = it.pos_y;
    pz = it.pos_z;
    r = '0;
    case (it.req_type)
      vwc_pkg::REQ_INSERT: begin
        for (i = 0; i < n_used; i++) begin
          cx = acc_x[i] / hits[i];
          cy = acc_y[i] / hits[i];
          cz = acc_z[i] / hits[i];
          d = sqr(px - cx) + sqr(py - cy) + sqr(pz - cz);
          if (d <= {16'b0, weld_r2}) begin
            r.cluster_index = i[5:0];
            if (hits[i] >= longint'(vwc_pkg::HIT_MAX)) begin
              r.status = vwc_pkg::ST_SATURATED;
            end else begin
              acc_x[i] += px;
              acc_y[i] += py;
              acc_z[i] += pz;
              hits[i]  += 1;
              cx = acc_x[i] / hits[i];
              cy = acc_y[i] / hits[i];
              cz = acc_z[i] / hits[i];
              r.status = vwc_pkg::ST_MERGED;
            end
            r.avg_x = cx[vwc_pkg::POS_W-1:0];
            r.avg_y = cy[vwc_pkg::POS_W-1:0];
            r.avg_z = cz[vwc_pkg::POS_W-1:0];
            r.cluster_count = n_used[6:0];
            return r;
          end
        end
        if (n_used >= vwc_pkg::MAX_CLUSTERS) begin
          r.status = vwc_pkg::ST_FULL;
        end else begin
          acc_x[n_used] = px;
          acc_y[n_used] = py;
          acc_z[n_used] = pz;
          hits[n_used]  = 1;
          r.status = vwc_pkg::ST_NEW;
          r.cluster_index = n_used[5:0];
          r.avg_x = it.pos_x;
          r.avg_y = it.pos_y;
          r.avg_z = it.pos_z;
          n_used++;
        end
      end
      vwc_pkg::REQ_READ: begin
        r.cluster_index = it.read_index;
        if (it.read_index >= n_used) begin
          r.status = vwc_pkg::ST_BAD_INDEX;
        end else begin
          i = it.read_index;
          cx = acc_x[i] / hits[i];
          cy = acc_y[i] / hits[i];
          cz = acc_z[i] / hits[i];
          r.status = vwc_pkg::ST_MERGED;
          r.avg_x = cx[vwc_pkg::POS_W-1:0];
          r.avg_y = cy[vwc_pkg::POS_W-1:0];
          r.avg_z = cz[vwc_pkg::POS_W-1:0];
        end
      end
      vwc_pkg::REQ_CLEAR: begin
        n_used = 0;
        r.status = vwc_pkg::ST_MERGED;
      end
      default: begin
        r.status = vwc_pkg::ST_BAD_INDEX;
      end
    endcase
    r.cluster_count = n_used[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch %s", $time, what);
    errors++;
  endtask

  task automatic check_result(vwc_pkg::out_item_t got, vwc_pkg::out_item_t want);
    if (got.status !== want.status)
      report_mismatch($sformatf("status: got %0d expected %0d",
                                got.status, want.status));
    if (got.cluster_index !== want.cluster_index)
      report_mismatch($sformatf("cluster_index: got %0d expected %0d",
                                got.cluster_index, want.cluster_index));
    if (got.avg_x !== want.avg_x)
      report_mismatch($sformatf("avg_x: got %0d expected %0d", got.avg_x, want.avg_x));
    if (got.avg_y !== want.avg_y)
      report_mismatch($sformatf("avg_y: got %0d expected %0d", got.avg_y, want.avg_y));
    if (got.avg_z !== want.avg_z)
      report_mismatch($sformatf("avg_z: got %0d expected %0d", got.avg_z, want.avg_z));
    if (got.cluster_count !== want.cluster_count)
      report_mismatch($sformatf("cluster_count: got %0d expected %0d",
                                got.cluster_count, want.cluster_count));
  endtask

  // Beat monitor, scoreboard and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result beat");
        end else begin
          check_result(out_data, pending_results.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        mon_pred = weld_predict(in_data);
        if (row_fixed && mon_pred !== row_want) begin
          report_mismatch("directed row: typed answer differs from the table model");
          mon_pred = row_want;
        end
        pending_results = {pending_results, mon_pred};
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        report_mismatch("timeout waiting for a beat");
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) < out_stall_pct) ? 1'b0 : 1'b1;
  end

  // Drives one request beat; returns at the edge where it was accepted.
  task automatic send_beat(vwc_pkg::in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= vwc_pkg::in_item_t'(80'({$urandom, $urandom, $urandom}));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Writes the weld radius, then reads it back.
  task automatic set_radius(logic [47:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= vwc_pkg::ADDR_RADIUS; pwdata <= {16'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    weld_r2 = v;
    penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[47:0] !== v)
      report_mismatch($sformatf("radius readback: got %0d expected %0d",
                                prdata[47:0], v));
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic vwc_pkg::in_item_t mk(logic [1:0] rt,
                                           logic signed [vwc_pkg::POS_W-1:0] x,
                                           logic signed [vwc_pkg::POS_W-1:0] y,
                                           logic signed [vwc_pkg::POS_W-1:0] z,
                                           logic [5:0] ri);
    vwc_pkg::in_item_t it;
    it.req_type = rt;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.read_index = ri;
    return it;
  endfunction

  function automatic vwc_pkg::out_item_t ans(logic [2:0] st, logic [5:0] idx,
                                             logic signed [vwc_pkg::POS_W-1:0] p,
                                             logic [6:0] cnt);
    vwc_pkg::out_item_t r;
    r.status = st;
    r.cluster_index = idx;
    r.avg_x = p;
    r.avg_y = p;
    r.avg_z = p;
    r.cluster_count = cnt;
    return r;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(vwc_pkg::in_item_t req, bit fixed,
                                  vwc_pkg::out_item_t want);
    vec_row_t row;
    row.req   = req;
    row.fixed = fixed;
    row.want  = want;
    vecs = {vecs, row};
  endfunction

  function automatic logic signed [vwc_pkg::POS_W-1:0] near(
      logic signed [vwc_pkg::POS_W-1:0] c);
    return c + $signed(24'($urandom_range(1024))) - 24'sd512;
  endfunction

  // One random request, mostly inserts, most of them around the eight centers.
  function automatic vwc_pkg::in_item_t random_req();
    vwc_pkg::in_item_t it;
    int       k, roll;
    it = vwc_pkg::in_item_t'(80'({$urandom, $urandom, $urandom}));
    roll = $urandom_range(99);
    if (roll < ((n_used > 10) ? 30 : 3)) begin
      it.req_type = vwc_pkg::REQ_CLEAR;
    end else if (roll < 42) begin
      it.req_type = vwc_pkg::REQ_READ;
      if (n_used > 0 && $urandom_range(99) < 75)
        it.read_index = 6'($urandom_range(n_used - 1));
    end else if (roll < 46) begin
      it.req_type = REQ_BAD;
    end else if (roll < 54) begin
      it.req_type = vwc_pkg::REQ_INSERT;
    end else begin
      k = $urandom_range(7);
      it.req_type = vwc_pkg::REQ_INSERT;
      it.pos_x = near(centers[k][0]);
      it.pos_y = near(centers[k][1]);
      it.pos_z = near(centers[k][2]);
    end
    return it;
  endfunction

  initial begin
    logic [47:0] radii[8];
    int          p, n;

    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    row_fixed = 1'b0;
    row_want = '0;
    errors = 0;
    quiet_cycles = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    n_used = 0;
    weld_r2 = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, weld radius zero: only exact duplicates merge.
    add_row(mk(vwc_pkg::REQ_READ, P0, P0, P0, 6'd0), 1'b1,
            ans(vwc_pkg::ST_BAD_INDEX, 6'd0, P0, 7'd0));
    add_row(mk(REQ_BAD, -24'sd1, -24'sd1, -24'sd1, 6'h3F), 1'b1,
            ans(vwc_pkg::ST_BAD_INDEX, 6'd0, P0, 7'd0));
    add_row(mk(vwc_pkg::REQ_INSERT, POS_MAX, POS_MAX, POS_MAX, 6'd0), 1'b1,
            ans(vwc_pkg::ST_NEW, 6'd0, POS_MAX, 7'd1));
    add_row(mk(vwc_pkg::REQ_INSERT, POS_MIN, POS_MIN, POS_MIN, 6'h3F), 1'b1,
            ans(vwc_pkg::ST_NEW, 6'd1, POS_MIN, 7'd2));
    add_row(mk(vwc_pkg::REQ_INSERT, POS_MAX, POS_MAX, POS_MAX, 6'd0), 1'b1,
            ans(vwc_pkg::ST_MERGED, 6'd0, POS_MAX, 7'd2));
    add_row(mk(vwc_pkg::REQ_INSERT, P0, P0, P0, 6'd0), 1'b1,
            ans(vwc_pkg::ST_NEW, 6'd2, P0, 7'd3));
    add_row(mk(vwc_pkg::REQ_READ, P0, P0, P0, 6'd1), 1'b1,
            ans(vwc_pkg::ST_MERGED, 6'd1, POS_MIN, 7'd3));
    add_row(mk(vwc_pkg::REQ_READ, P0, P0, P0, 6'h3F), 1'b1,
            ans(vwc_pkg::ST_BAD_INDEX, 6'h3F, P0, 7'd3));
    add_row(mk(vwc_pkg::REQ_READ, P0, P0, P0, 6'd3), 1'b1,
            ans(vwc_pkg::ST_BAD_INDEX, 6'd3, P0, 7'd3));
    add_row(mk(vwc_pkg::REQ_INSERT, -24'sd1, 24'sd1, -24'sd256, 6'h2A), 1'b0, '0);
    add_row(mk(vwc_pkg::REQ_INSERT, -24'sd1, 24'sd1, -24'sd256, 6'h15), 1'b0, '0);
    add_row(mk(vwc_pkg::REQ_INSERT, -24'sd2, 24'sd2, -24'sd255, 6'd0), 1'b0, '0);
    add_row(mk(vwc_pkg::REQ_READ, P0, P0, P0, 6'd3), 1'b0, '0);
    add_row(mk(vwc_pkg::REQ_INSERT, 24'sh555555, 24'shAAAAAA, 24'sh555555, 6'd0),
            1'b0, '0);
    add_row(mk(vwc_pkg::REQ_INSERT, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 6'd0),
            1'b0, '0);
    add_row(mk(vwc_pkg::REQ_READ, P0, P0, P0, 6'd0), 1'b0, '0);
    add_row(mk(REQ_BAD, P0, P0, P0, 6'd0), 1'b1,
            ans(vwc_pkg::ST_BAD_INDEX, 6'd0, P0, 7'd7));
    add_row(mk(vwc_pkg::REQ_CLEAR, POS_MAX, P0, POS_MIN, 6'h3F), 1'b1,
            ans(vwc_pkg::ST_MERGED, 6'd0, P0, 7'd0));
    add_row(mk(vwc_pkg::REQ_READ, P0, P0, P0, 6'd0), 1'b1,
            ans(vwc_pkg::ST_BAD_INDEX, 6'd0, P0, 7'd0));
    foreach (vecs[i]) begin
      row_fixed <= vecs[i].fixed;
      row_want  <= vecs[i].want;
      send_beat(vecs[i].req);
    end
    row_fixed <= 1'b0;
    drain();

    // Fill the table with distinct vertices until it reports full.
    set_radius('0);
    send_beat(mk(vwc_pkg::REQ_CLEAR, P0, P0, P0, 6'd0));
    for (n = 0; n < vwc_pkg::MAX_CLUSTERS + 3; n++)
      send_beat(mk(vwc_pkg::REQ_INSERT, 24'(n * 4099), -24'(n * 771), 24'(n * 33),
                   6'd0));
    send_beat(mk(vwc_pkg::REQ_INSERT, 24'(5 * 4099), -24'(5 * 771), 24'(5 * 33), 6'd0));
    send_beat(mk(vwc_pkg::REQ_READ, P0, P0, P0, 6'd63));
    send_beat(mk(vwc_pkg::REQ_READ, P0, P0, P0, 6'd5));
    send_beat(mk(vwc_pkg::REQ_CLEAR, P0, P0, P0, 6'd0));
    drain();

    // Random phases over several radii and idling patterns.
    radii[0] = '0;
    radii[1] = RADIUS_MAX;
    radii[2] = 48'd786432;
    radii[3] = 48'd100;
    radii[4] = 48'({$urandom, $urandom}) & 48'h0000_FFFF_FFFF;
    radii[5] = RADIUS_MAX;
    radii[6] = 48'd3000000;
    radii[7] = 48'({$urandom, $urandom});
    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 55; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 55; end
        default: begin in_idle_pct = 26; out_stall_pct = 26; end
      endcase
      foreach (centers[k]) begin
        centers[k][0] = 24'($urandom_range(8000000)) - 24'sd4000000;
        centers[k][1] = 24'($urandom_range(8000000)) - 24'sd4000000;
        centers[k][2] = 24'($urandom_range(8000000)) - 24'sd4000000;
      end
      set_radius(radii[p]);
      for (n = 0; n < 85; n++) send_beat(random_req());
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
